/* hw/rtl/stlfd_pkg.sv */
// Shared types and constants for the sync/type/length frame deframer.
package stlfd_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND = 8'hBB;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   typedef enum logic [0:0] {
      REG_MAX_PAYLOAD_LENGTH = 1'b0,
      REG_UNUSED             = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      PH_HUNT0   = 3'd0,
      PH_HUNT1   = 3'd1,
      PH_TYPE    = 3'd2,
      PH_LEN0    = 3'd3,
      PH_LEN1    = 3'd4,
      PH_LEN2    = 3'd5,
      PH_LEN3    = 3'd6,
      PH_PAYLOAD = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER   = 2'd0,
      KIND_DATA     = 2'd1,
      KIND_TOO_LONG = 2'd2
   } item_kind_type;

   typedef struct packed {
      item_kind_type item_kind;
      logic [7:0]    frame_type;
      logic [31:0]   frame_length;
      logic [7:0]    data_byte;
      logic          frame_last;
   } result_type;

endpackage

/* hw/rtl/stlfd_csr.sv */
// Configuration register file: holds the maximum payload length.
module stlfd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [stlfd_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [stlfd_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [stlfd_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready,
   output logic [31:0]                         max_payload_length
);
   import stlfd_pkg::*;

   reg_index_type reg_index;
   logic          write_en;
   logic [31:0]   max_len_ff;
   logic [31:0]   max_len_in;

   assign reg_index = reg_index_type'(paddr[CSR_ADDR_WIDTH-1]);
   assign write_en  = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      max_len_in = max_len_ff;
      if (write_en && (reg_index == REG_MAX_PAYLOAD_LENGTH)) begin
         max_len_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= 32'd8192;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   always_comb begin
      case (reg_index)
         REG_MAX_PAYLOAD_LENGTH: prdata = max_len_ff;
         default:                prdata = '0;
      endcase
   end

   assign max_payload_length = max_len_ff;

endmodule

/* hw/rtl/stlfd_parser.sv */
// Frame parser: phase state machine, header capture and result formation.
module stlfd_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            rx_byte,
   input  logic [31:0]           max_payload_length,
   output logic                  result_valid,
   output stlfd_pkg::result_type result
);
   import stlfd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  type_ff, type_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [31:0] shifted_length;
   logic [31:0] remaining_dec;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT0;
         type_ff      <= '0;
         length_ff    <= '0;
         remaining_ff <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         type_ff      <= type_in;
         length_ff    <= length_in;
         remaining_ff <= remaining_in;
      end
   end

   assign shifted_length = {length_ff[23:0], rx_byte};
   assign remaining_dec  = (remaining_ff != 32'd0) ? remaining_ff - 32'd1 : remaining_ff;

   always_comb begin
      phase_in            = phase_ff;
      type_in             = type_ff;
      length_in           = length_ff;
      remaining_in        = remaining_ff;
      result_valid        = 1'b0;
      result.item_kind    = KIND_HEADER;
      result.frame_type   = type_ff;
      result.frame_length = length_ff;
      result.data_byte    = 8'd0;
      result.frame_last   = 1'b0;
      case (phase_ff)
         PH_HUNT0: begin
            if (rx_byte == SYNC_FIRST) begin
               phase_in = PH_HUNT1;
            end
         end
         PH_HUNT1: begin
            // any byte but the second sync byte restarts the hunt
            phase_in = (rx_byte == SYNC_SECOND) ? PH_TYPE : PH_HUNT0;
         end
         PH_TYPE: begin
            type_in   = rx_byte;
            length_in = '0;
            phase_in  = PH_LEN0;
         end
         PH_LEN0, PH_LEN1, PH_LEN2: begin
            length_in = shifted_length;
            phase_in  = phase_type'(phase_ff + 3'd1);
         end
         PH_LEN3: begin
            length_in           = shifted_length;
            result_valid        = 1'b1;
            result.frame_length = shifted_length;
            if (shifted_length > max_payload_length) begin
               phase_in          = PH_HUNT0;
               remaining_in      = '0;
               result.item_kind  = KIND_TOO_LONG;
               result.frame_last = 1'b1;
            end else begin
               remaining_in      = shifted_length;
               result.item_kind  = KIND_HEADER;
               result.frame_last = (shifted_length == 32'd0);
               phase_in          = (shifted_length == 32'd0) ? PH_HUNT0 : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            remaining_in      = remaining_dec;
            result_valid      = 1'b1;
            result.item_kind  = KIND_DATA;
            result.data_byte  = rx_byte;
            result.frame_last = (remaining_dec == 32'd0);
            if (remaining_dec == 32'd0) begin
               phase_in = PH_HUNT0;
            end
         end
         default: begin
            phase_in = PH_HUNT0;
         end
      endcase
   end

endmodule

/* hw/rtl/stlfd_out_buf.sv */
// Two-entry result buffer that decouples the parser from a stalling receiver.
module stlfd_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  stlfd_pkg::result_type push_data,
   output logic                  full,
   output logic                  pop_valid,
   input  logic                  pop_stall,
   output stlfd_pkg::result_type pop_data
);
   import stlfd_pkg::*;

   result_type  entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop       = pop_valid && !pop_stall;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/sync_type_length_frame_deframer.sv */
// Top level of the sync/type/length frame deframer.
//
// Feed one received byte per request on the req_ channel. The block hunts for
// the sync pair 0xAA 0xBB, takes a type byte and a big-endian 32-bit length,
// then yields one header result followed by one result per payload byte on
// the rsp_ channel; the final item of a frame carries frame_last. A length
// above max_payload_length yields a single error result and hunting resumes.
// Sync, type and leading length bytes yield no result.
// Each request is parsed in the cycle it is accepted; its result, if any, is
// buffered and presented on rsp_ once older results are taken. One request is
// taken every cycle, sustained, as long as the receiver keeps up; the phase
// register and the header/length registers are updated in a single pass.
// A two-entry result buffer lets requests keep flowing while a result waits;
// req_stall rises only when both entries hold results the receiver stalls on.
// Reset (synchronous) returns the parser to hunting, empties the buffer and
// sets max_payload_length to 8192. Write the register only while idle.
module sync_type_length_frame_deframer (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_rx_byte,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_item_kind,
   output logic [7:0]                          rsp_frame_type,
   output logic [31:0]                         rsp_frame_length,
   output logic [7:0]                          rsp_data_byte,
   output logic                                rsp_frame_last,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [stlfd_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [stlfd_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [stlfd_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready
);
   import stlfd_pkg::*;

   logic        buf_full;
   logic        req_accept;
   logic        parse_valid;
   logic [31:0] max_payload_length;
   result_type  parse_result;
   result_type  rsp_result;

   // hold off requests only when no buffer entry is free
   assign req_stall  = buf_full;
   assign req_accept = req_valid && !buf_full;

   stlfd_csr u_csr (
      .clock              (clock),
      .reset              (reset),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready),
      .max_payload_length (max_payload_length)
   );

   stlfd_parser u_parser (
      .clock              (clock),
      .reset              (reset),
      .accept             (req_accept),
      .rx_byte            (req_rx_byte),
      .max_payload_length (max_payload_length),
      .result_valid       (parse_valid),
      .result             (parse_result)
   );

   // push only results of accepted requests
   stlfd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept && parse_valid),
      .push_data (parse_result),
      .full      (buf_full),
      .pop_valid (rsp_valid),
      .pop_stall (rsp_stall),
      .pop_data  (rsp_result)
   );

   assign rsp_item_kind    = rsp_result.item_kind;
   assign rsp_frame_type   = rsp_result.frame_type;
   assign rsp_frame_length = rsp_result.frame_length;
   assign rsp_data_byte    = rsp_result.data_byte;
   assign rsp_frame_last   = rsp_result.frame_last;

endmodule

/* tb/sync_type_length_frame_deframer_tb.sv */
// Self-checking testbench for the sync/type/length deframer: directed frames, random traffic.
module sync_type_length_frame_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import stlfd_pkg::*;

   // Quiet cycles tolerated before the run is declared hung; covers register
   // accesses, drain waits and the longest receiver stall many times over.
   localparam int QUIET_LIMIT = 4000;
   // Extra cycles after the last result.
   localparam int SETTLE_CYCLES = 8;
   localparam logic [CSR_ADDR_WIDTH-1:0] MAX_LEN_ADDR =
      CSR_ADDR_WIDTH'(4 * int'(REG_MAX_PAYLOAD_LENGTH));

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC
   } stall_pattern_type;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_rx_byte = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   logic [1:0]                rsp_item_kind;
   logic [7:0]                rsp_frame_type;
   logic [31:0]               rsp_frame_length;
   logic [7:0]                rsp_data_byte;
   logic                      rsp_frame_last;
   logic                      psel        = 1'b0;
   logic                      penable     = 1'b0;
   logic                      pwrite      = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr       = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata      = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   // Shadow of the parser: phase, held header fields and the length limit.
   phase_type   track_phase  = PH_HUNT0;
   logic [7:0]  track_type   = '0;
   logic [31:0] track_length = '0;
   logic [31:0] track_left   = '0;
   logic [31:0] length_limit = 32'd8192;

   // Deframed items still owed by the block, oldest first.
   result_type parsed_items[$];

   int          burst_left   = 0;
   int          quiet_cycles = 0;
   int unsigned stall_tick   = 0;
   stall_pattern_type stall_pattern = STALL_NONE;

   int n_bytes    = 0;
   int n_headers  = 0;
   int n_payload  = 0;
   int n_errors   = 0;
   int n_mismatch = 0;

   sync_type_length_frame_deframer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_frame_length (rsp_frame_length),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_frame_last   (rsp_frame_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Advance the shadow parser by one byte; return 1 and fill item when the
   // byte yields a result.
   function automatic bit parse_rx_byte(input logic [7:0] b, output result_type item);
      bit has_item;
      has_item = 1'b0;
      item     = '0;
      case (track_phase)
         PH_HUNT0: begin
            if (b == SYNC_FIRST) track_phase = PH_HUNT1;
         end
         PH_HUNT1: begin
            // anything but the second sync byte drops back to hunting,
            // a repeated first sync byte included
            track_phase = (b == SYNC_SECOND) ? PH_TYPE : PH_HUNT0;
         end
         PH_TYPE: begin
            track_type   = b;
            track_length = '0;
            track_phase  = PH_LEN0;
         end
         PH_PAYLOAD: begin
            if (track_left != 0) track_left--;
            item.item_kind    = KIND_DATA;
            item.frame_type   = track_type;
            item.frame_length = track_length;
            item.data_byte    = b;
            item.frame_last   = (track_left == 0);
            if (track_left == 0) track_phase = PH_HUNT0;
            has_item = 1'b1;
         end
         default: begin
            // length bytes arrive most significant first
            track_length = {track_length[23:0], b};
            if (track_phase != PH_LEN3) begin
               track_phase = phase_type'(track_phase + 3'd1);
            end else begin
               has_item          = 1'b1;
               item.frame_type   = track_type;
               item.frame_length = track_length;
               item.frame_last   = 1'b1;
               if (track_length > length_limit) begin
                  item.item_kind = KIND_TOO_LONG;
                  track_left     = '0;
                  track_phase    = PH_HUNT0;
               end else begin
                  item.item_kind  = KIND_HEADER;
                  item.frame_last = (track_length == 0);
                  track_left      = track_length;
                  track_phase     = (track_length == 0) ? PH_HUNT0 : PH_PAYLOAD;
               end
            end
         end
      endcase
      return has_item;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         n_mismatch++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   function automatic logic [7:0] random_byte_except(input logic [7:0] banned);
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == banned);
      return b;
   endfunction

   // Mostly short lengths the limit admits, with the limit itself (capped at 64),
   // one past it, and full 32-bit random values, which the limit mostly rejects.
   function automatic logic [31:0] pick_length(input logic [31:0] limit);
      logic [31:0] len;
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
         len = '0;
      end else if (roll <= 6) begin
         len = (limit == 0) ? 32'd0 : 32'($urandom_range(1, (limit < 16) ? limit : 16));
      end else if (roll == 7) begin
         len = (limit <= 64) ? limit : 32'd64;
      end else if (roll == 8 && limit != '1) begin
         len = limit + 32'd1;
      end else begin
         len = $urandom;
         // hold accepted lengths short so frames stay cheap
         if (len <= limit && len > 64) len = len & 32'hF;
      end
      return len;
   endfunction

   // Present one byte; the sender runs in bursts with random gaps, and some
   // bursts start with no gap at all.
   task automatic send_byte(input logic [7:0] b);
      result_type item;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 6);
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid   = 1'b1;
      req_rx_byte = b;
      do @(posedge clock); while (req_stall);
      burst_left--;
      n_bytes++;
      if (parse_rx_byte(b, item)) parsed_items.push_back(item);
   endtask

   // Sync pair, type, big-endian length, then body_count random payload bytes.
   task automatic send_frame(input logic [7:0] ftype, input logic [31:0] len,
                             input int body_count);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(ftype);
      for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
      repeat (body_count) send_byte(8'($urandom_range(0, 255)));
   endtask

   // Drop valid, drain every owed result, then let the pipeline empty.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (parsed_items.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the length limit while idle, then read it back.
   task automatic write_max_length(input logic [31:0] value);
      settle();
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = MAX_LEN_ADDR;
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      length_limit = value;
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      check_field("max_payload_length readback", value, prdata);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   // Broken sync on a repeated first sync byte must not start a frame; then
   // an empty frame yields a lone header flagged last.
   task automatic test_sync_and_empty_frame();
      send_byte(SYNC_FIRST);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(8'h7E);
      repeat (4) send_byte(8'h00);
      send_frame(8'hFF, 32'd0, 0);
   endtask

   // With the reset limit, one past it is rejected and a short frame passes.
   task automatic test_reset_limit();
      send_frame(8'h5A, 32'd8193, 0);
      send_frame(8'h00, 32'd1, 1);
   endtask

   // All-ones length against a limit just below it, then a short frame.
   task automatic test_top_length_boundary();
      write_max_length(32'hFFFF_FFFE);
      send_frame(8'hC3, 32'hFFFF_FFFF, 0);
      send_frame(8'h3C, 32'd2, 2);
   endtask

   // Random frames under one limit, mixed with line noise and broken syncs.
   task automatic test_random_traffic(input logic [31:0] limit, input int quota);
      int          frame_bytes;
      int          body;
      int unsigned roll;
      logic [31:0] len;
      write_max_length(limit);
      frame_bytes = 0;
      while (frame_bytes < quota) begin
         roll = $urandom_range(0, 99);
         if (roll < 72) begin
            len  = pick_length(limit);
            body = (len <= limit) ? int'(len) : 0;
            send_frame(8'($urandom_range(0, 255)), len, body);
            frame_bytes += 7 + body;
         end else if (roll < 86) begin
            // noise never holds the first sync byte, so the next frame is found
            repeat ($urandom_range(1, 5)) send_byte(random_byte_except(SYNC_FIRST));
         end else begin
            send_byte(SYNC_FIRST);
            if ($urandom_range(0, 1) == 0) send_byte(SYNC_FIRST);
            else send_byte(random_byte_except(SYNC_SECOND));
         end
      end
   endtask

   // Receiver stall: the pattern switches, on a period of stall_tick, among none,
   // random and a periodic stall.
   always @(negedge clock) begin
      stall_tick++;
      if (stall_tick % 150 == 0) begin
         stall_pattern = stall_pattern_type'($urandom_range(0, 2));
      end
      case (stall_pattern)
         STALL_NONE:   rsp_stall = 1'b0;
         STALL_RANDOM: rsp_stall = ($urandom_range(0, 2) == 0);
         default:      rsp_stall = (stall_tick % 7) < 3;
      endcase
   end

   // Compare each accepted result against the oldest owed item.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (parsed_items.size() == 0) begin
            n_mismatch++;
            $display("%0t: unexpected result: expected none, actual kind %0d type %0h length %0h",
                     $time, rsp_item_kind, rsp_frame_type, rsp_frame_length);
         end else begin
            want = parsed_items.pop_front();
            check_field("item_kind", want.item_kind, rsp_item_kind);
            check_field("frame_type", want.frame_type, rsp_frame_type);
            check_field("frame_length", want.frame_length, rsp_frame_length);
            check_field("data_byte", want.data_byte, rsp_data_byte);
            check_field("frame_last", want.frame_last, rsp_frame_last);
            case (want.item_kind)
               KIND_HEADER: n_headers++;
               KIND_DATA:   n_payload++;
               default:     n_errors++;
            endcase
         end
      end
   end

   // Watchdog: end the run when neither channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: timeout, no request or result moved for %0d cycles", $time, QUIET_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_sync_and_empty_frame();
      test_reset_limit();
      test_top_length_boundary();
      test_random_traffic(32'($urandom_range(1, 40)), 260);
      test_random_traffic(32'd0, 260);
      test_random_traffic(32'hFFFF_FFFF, 260);
      test_random_traffic(32'd8192, 260);
      test_random_traffic($urandom, 260);

      settle();
      if (parsed_items.size() != 0) begin
         n_mismatch += parsed_items.size();
         $display("%0t: %0d expected results never arrived", $time, parsed_items.size());
      end
      $display("Sent %0d bytes; checked %0d headers, %0d payload bytes, %0d oversize errors.",
               n_bytes, n_headers, n_payload, n_errors);
      $display("Limits: reset value, small, zero, all-ones, all-ones minus one, random.");
      if (n_mismatch == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/stlfd_pkg.sv
hw/rtl/stlfd_csr.sv
hw/rtl/stlfd_parser.sv
hw/rtl/stlfd_out_buf.sv
hw/rtl/sync_type_length_frame_deframer.sv
tb/sync_type_length_frame_deframer_tb.sv
